@@ hdl/max_spanning_tree_bottleneck_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the maximum spanning tree bottleneck block
// They expand to concurrent assertions in simulation and to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef MAX_SPANNING_TREE_BOTTLENECK_ASSERT_SVH
`define MAX_SPANNING_TREE_BOTTLENECK_ASSERT_SVH
`ifndef SYNTHESIS
`define MSTB_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define MSTB_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define MSTB_ASSERT(label, prop)
`define MSTB_ASSERT_ALWAYS(label, prop)
`endif
`endif

@@ hdl/mstb_pkg.sv @@
// ----------------------------------------------------------------------------
// mstb_pkg
// Types and defaults shared by the maximum spanning tree bottleneck block.
// ----------------------------------------------------------------------------
package mstb_pkg;

    localparam int MAX_EDGES_DEF = 1024;
    localparam int MAX_NODES_DEF = 256;
    localparam int CAP_BITS_DEF  = 31;
    localparam int NODE_CNT_RST  = 256;

    typedef struct packed {
        logic [7:0]  node_a;
        logic [7:0]  node_b;
        logic [30:0] capacity;
        logic        last_edge;
    } item_t;

    typedef struct packed {
        logic [30:0] bottleneck;
        logic        found;
        logic        overflow;
    } result_t;

    typedef enum logic [3:0] {
        S_LOAD,
        S_CLEAR,
        S_SCAN_RD,
        S_SCAN_EV,
        S_MATCH_RD,
        S_MATCH_EV,
        S_FINDA_RD,
        S_FINDA_EV,
        S_FINDB_RD,
        S_FINDB_EV,
        S_DONE
    } state_t;

endpackage

@@ hdl/max_spanning_tree_bottleneck.sv @@
// ----------------------------------------------------------------------------
// max_spanning_tree_bottleneck
// Stores one graph's edges, then runs Kruskal in descending capacity order
// over a parent memory and returns the smallest capacity of the tree edges.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  item      in         item_valid/item_stall    mstb_pkg::item_t
//  result    out        result_valid/result_stall mstb_pkg::result_t
//  cfg       in         cfg_valid/cfg_ready      node_count (9 bits)
//
// An edge is stored as it is accepted while there is room. After the last
// edge the parent memory is set to identity; then each capacity level is
// found by a scan of the stored edges and applied by a second pass, with
// parent memory reads in each find. A last scan finds no lower level, and the
// result register is then loaded. Items stall during that time. An earlier
// result still waiting on result_stall holds the block in its final state.
// ----------------------------------------------------------------------------
module max_spanning_tree_bottleneck #(
    parameter int MAX_EDGES = mstb_pkg::MAX_EDGES_DEF,
    parameter int MAX_NODES = mstb_pkg::MAX_NODES_DEF,
    parameter int CAP_BITS  = mstb_pkg::CAP_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  mstb_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output mstb_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [8:0]        cfg_data
);

    localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int EW = 16 + CAP_BITS;

    mstb_pkg::state_t state_reg, state_next;

    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                ovf_reg, ovf_next;
    logic [8:0]          nodecnt_reg;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [NW-1:0]       clr_reg, clr_next;
    logic [CAP_BITS-1:0] level_reg, level_next;
    logic [CAP_BITS-1:0] best_reg, best_next;
    logic                have_reg, have_next;
    logic                first_reg, first_next;
    logic [7:0]          b_reg, b_next;
    logic [NW-1:0]       x_reg, x_next;
    logic [NW-1:0]       ra_reg, ra_next;
    logic [CAP_BITS-1:0] rcap_reg, rcap_next;
    logic                found_reg, found_next;
    logic                out_valid_reg, out_valid_next;
    mstb_pkg::result_t   out_reg, out_next;

    logic [EW-1:0]       emem [MAX_EDGES];
    logic [EW-1:0]       eq_reg;
    logic [NW-1:0]       pmem [MAX_NODES];
    logic [NW-1:0]       pq_reg;

    logic                e_we;
    logic [AW-1:0]       e_raddr;
    logic                p_we;
    logic [NW-1:0]       p_waddr, p_wdata, p_raddr;

    logic                accept;
    logic                room;
    logic                last_idx;
    logic                clr_last;
    logic                out_free;
    logic [7:0]          e_a, e_b;
    logic [CAP_BITS-1:0] e_cap;
    logic [16:0]         lim, a_ext, b_ext, bq_ext;
    logic                in_range;
    logic                cand, take, have_eff;
    logic [CAP_BITS-1:0] best_eff;

    assign item_stall   = (state_reg != mstb_pkg::S_LOAD);
    assign accept       = item_valid && !item_stall;
    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign room     = (cnt_reg < CW'(MAX_EDGES));
    assign last_idx = ((CW'(idx_reg) + CW'(1)) == cnt_reg);
    assign clr_last = (clr_reg == NW'(MAX_NODES - 1));
    assign out_free = !out_valid_reg || !result_stall;

    assign e_a   = eq_reg[EW-1 -: 8];
    assign e_b   = eq_reg[EW-9 -: 8];
    assign e_cap = eq_reg[CAP_BITS-1:0];

    assign lim      = (17'(nodecnt_reg) > 17'(MAX_NODES)) ? 17'(MAX_NODES)
                                                          : 17'(nodecnt_reg);
    assign a_ext    = 17'(e_a);
    assign b_ext    = 17'(e_b);
    assign bq_ext   = 17'(b_reg);
    assign in_range = (a_ext < lim) && (b_ext < lim);

    assign cand     = first_reg || (e_cap < level_reg);
    assign take     = cand && (!have_reg || (e_cap > best_reg));
    assign have_eff = have_reg || cand;
    assign best_eff = take ? e_cap : best_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mstb_pkg::S_LOAD:
            begin
                if (accept && item.last_edge)
                    state_next = mstb_pkg::S_CLEAR;
            end
            mstb_pkg::S_CLEAR:
            begin
                if (clr_last)
                    state_next = mstb_pkg::S_SCAN_RD;
            end
            mstb_pkg::S_SCAN_RD:
                state_next = mstb_pkg::S_SCAN_EV;
            mstb_pkg::S_SCAN_EV:
            begin
                if (!last_idx)
                    state_next = mstb_pkg::S_SCAN_RD;
                else if (have_eff)
                    state_next = mstb_pkg::S_MATCH_RD;
                else
                    state_next = mstb_pkg::S_DONE;
            end
            mstb_pkg::S_MATCH_RD:
                state_next = mstb_pkg::S_MATCH_EV;
            mstb_pkg::S_MATCH_EV:
            begin
                if ((e_cap == level_reg) && in_range)
                    state_next = mstb_pkg::S_FINDA_RD;
                else if (last_idx)
                    state_next = mstb_pkg::S_SCAN_RD;
                else
                    state_next = mstb_pkg::S_MATCH_RD;
            end
            mstb_pkg::S_FINDA_RD:
                state_next = mstb_pkg::S_FINDA_EV;
            mstb_pkg::S_FINDA_EV:
            begin
                if (pq_reg == x_reg)
                    state_next = mstb_pkg::S_FINDB_RD;
                else
                    state_next = mstb_pkg::S_FINDA_RD;
            end
            mstb_pkg::S_FINDB_RD:
                state_next = mstb_pkg::S_FINDB_EV;
            mstb_pkg::S_FINDB_EV:
            begin
                if (pq_reg != x_reg)
                    state_next = mstb_pkg::S_FINDB_RD;
                else if (last_idx)
                    state_next = mstb_pkg::S_SCAN_RD;
                else
                    state_next = mstb_pkg::S_MATCH_RD;
            end
            mstb_pkg::S_DONE:
            begin
                if (out_free)
                    state_next = mstb_pkg::S_LOAD;
            end
            default:
                state_next = mstb_pkg::S_LOAD;
        endcase
    end

    always_comb
    begin
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        idx_next       = idx_reg;
        clr_next       = clr_reg;
        level_next     = level_reg;
        best_next      = best_reg;
        have_next      = have_reg;
        first_next     = first_reg;
        b_next         = b_reg;
        x_next         = x_reg;
        ra_next        = ra_reg;
        rcap_next      = rcap_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_next       = out_reg;
        e_we           = 1'b0;
        e_raddr        = idx_reg;
        p_we           = 1'b0;
        p_waddr        = clr_reg;
        p_wdata        = clr_reg;
        p_raddr        = x_reg;
        case (state_reg)
            mstb_pkg::S_LOAD:
            begin
                clr_next = '0;
                if (accept)
                begin
                    if (room)
                    begin
                        e_we     = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            mstb_pkg::S_CLEAR:
            begin
                p_we       = 1'b1;
                clr_next   = clr_reg + NW'(1);
                idx_next   = '0;
                have_next  = 1'b0;
                first_next = 1'b1;
                found_next = 1'b0;
                rcap_next  = '0;
            end
            mstb_pkg::S_SCAN_EV:
            begin
                have_next = have_eff;
                best_next = best_eff;
                idx_next  = last_idx ? '0 : idx_reg + AW'(1);
                if (last_idx)
                begin
                    level_next = best_eff;
                    first_next = 1'b0;
                end
            end
            mstb_pkg::S_MATCH_EV:
            begin
                b_next = e_b;
                x_next = a_ext[NW-1:0];
                if (!((e_cap == level_reg) && in_range))
                begin
                    idx_next = last_idx ? '0 : idx_reg + AW'(1);
                    if (last_idx)
                        have_next = 1'b0;
                end
            end
            mstb_pkg::S_FINDA_EV:
            begin
                if (pq_reg == x_reg)
                begin
                    ra_next = x_reg;
                    x_next  = bq_ext[NW-1:0];
                end
                else
                begin
                    x_next = pq_reg;
                end
            end
            mstb_pkg::S_FINDB_EV:
            begin
                if (pq_reg == x_reg)
                begin
                    if (ra_reg != x_reg)
                    begin
                        p_we       = 1'b1;
                        p_waddr    = ra_reg;
                        p_wdata    = x_reg;
                        found_next = 1'b1;
                        rcap_next  = level_reg;
                    end
                    idx_next = last_idx ? '0 : idx_reg + AW'(1);
                    if (last_idx)
                        have_next = 1'b0;
                end
                else
                begin
                    x_next = pq_reg;
                end
            end
            mstb_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.bottleneck = 31'(rcap_reg);
                    out_next.found      = found_reg;
                    out_next.overflow   = ovf_reg;
                    cnt_next            = '0;
                    ovf_next            = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (e_we)
            emem[cnt_reg[AW-1:0]] <= {item.node_a, item.node_b, item.capacity[CAP_BITS-1:0]};
        eq_reg <= emem[e_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
            pmem[p_waddr] <= p_wdata;
        pq_reg <= pmem[p_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mstb_pkg::S_LOAD;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            nodecnt_reg   <= 9'(mstb_pkg::NODE_CNT_RST);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                nodecnt_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        clr_reg   <= clr_next;
        level_reg <= level_next;
        best_reg  <= best_next;
        have_reg  <= have_next;
        first_reg <= first_next;
        b_reg     <= b_next;
        x_reg     <= x_next;
        ra_reg    <= ra_next;
        rcap_reg  <= rcap_next;
        found_reg <= found_next;
        out_reg   <= out_next;
    end

`include "max_spanning_tree_bottleneck_assert.svh"

    `MSTB_ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= CW'(MAX_EDGES))
    `MSTB_ASSERT(a_result_from_done, $rose(result_valid) |-> $past(state_reg) == mstb_pkg::S_DONE)
    `MSTB_ASSERT(a_not_found_zero, (result_valid && !result.found) |-> result.bottleneck == '0)

endmodule
